// File: rtl/core/cmta_pkg.sv
// shared types, byte codes and helpers for the caret markup to ansi translator
package cmta_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned AddrW     = 1;
  localparam int unsigned DataW     = 32;

  // register map
  localparam logic [AddrW-1:0] RegColourEnable = '0;

  localparam logic [7:0] ByteEsc   = 8'h1B;
  localparam logic [7:0] ByteCaret = 8'h5E;
  localparam logic [7:0] ByteSlash = 8'h2F;
  localparam logic [7:0] ByteNl    = 8'h0A;
  localparam logic [7:0] ByteCr    = 8'h0D;
  localparam logic [7:0] ByteLbr   = 8'h5B;
  localparam logic [7:0] ByteM     = 8'h6D;
  localparam logic [7:0] ByteZero  = 8'h30;
  localparam logic [7:0] ByteOne   = 8'h31;
  localparam logic [7:0] ByteThree = 8'h33;
  localparam logic [7:0] ByteUpH   = 8'h48;
  localparam logic [7:0] ByteUpN   = 8'h4E;
  localparam logic [7:0] ByteLowA  = 8'h61;

  // output segments, in emission order
  localparam int unsigned SegPre   = 0;
  localparam int unsigned SegReset = 1;
  localparam int unsigned SegBold  = 2;
  localparam int unsigned SegFg    = 3;
  localparam int unsigned SegByte  = 4;
  localparam int unsigned SegCrlf  = 5;
  localparam int unsigned SegPost  = 6;
  localparam int unsigned NumSegs  = 7;

  // flattened byte positions of all segments
  localparam int unsigned NumPos = 18;
  localparam int unsigned PosW   = 5;

  typedef logic [NumSegs-1:0] seg_t;
  typedef logic [NumPos-1:0]  pos_t;

  typedef struct packed {
    seg_t       seg;
    logic [7:0] data;
    logic [2:0] digit;
  } cmd_t;

  function automatic logic [2:0] colour_digit(input logic [7:0] b);
    logic [2:0] d;
    case (b | 8'h20)
      8'h72:   d = 3'd1;  // r
      8'h67:   d = 3'd2;  // g
      8'h79:   d = 3'd3;  // y
      8'h62:   d = 3'd4;  // b
      8'h6D:   d = 3'd5;  // m
      8'h63:   d = 3'd6;  // c
      8'h77:   d = 3'd7;  // w
      default: d = 3'd0;
    endcase
    return d;
  endfunction

  function automatic pos_t expand_segs(input seg_t s);
    pos_t p;
    p        = '0;
    p[0]     = s[SegPre];
    p[4:1]   = {4{s[SegReset]}};
    p[8:5]   = {4{s[SegBold]}};
    p[13:9]  = {5{s[SegFg]}};
    p[14]    = s[SegByte];
    p[16:15] = {2{s[SegCrlf]}};
    p[17]    = s[SegPost];
    return p;
  endfunction

  function automatic logic [7:0] pos_byte(input logic [PosW-1:0] idx,
                                          input logic [7:0] data,
                                          input logic [2:0] digit);
    logic [7:0] r;
    case (idx)
      5'd0:    r = ByteSlash;
      5'd1:    r = ByteEsc;
      5'd2:    r = ByteLbr;
      5'd3:    r = ByteZero;
      5'd4:    r = ByteM;
      5'd5:    r = ByteEsc;
      5'd6:    r = ByteLbr;
      5'd7:    r = ByteOne;
      5'd8:    r = ByteM;
      5'd9:    r = ByteEsc;
      5'd10:   r = ByteLbr;
      5'd11:   r = ByteThree;
      5'd12:   r = ByteZero + {5'd0, digit};
      5'd13:   r = ByteM;
      5'd14:   r = data;
      5'd15:   r = ByteCr;
      5'd16:   r = ByteNl;
      5'd17:   r = ByteSlash;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/cmta_front.sv
// front end: accepts text items, tracks pending caret and slash, builds commands
module cmta_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          colour_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    text_byte_i,
  input  logic          end_of_message_i,
  input  logic          full_i,
  output logic          push_o,
  output cmta_pkg::cmd_t cmd_o
);
  import cmta_pkg::*;

  logic caret_q, caret_d;
  logic slash_q, slash_d;
  logic accept;
  logic do_plain;
  logic [2:0] dig;
  seg_t seg;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign dig        = colour_digit(text_byte_i);

  always_comb begin
    seg      = '0;
    caret_d  = 1'b0;
    slash_d  = 1'b0;
    do_plain = 1'b0;
    if (caret_q) begin
      if (colour_i) begin
        if (text_byte_i == ByteUpH) begin
          seg[SegBold] = 1'b1;
        end else if (text_byte_i == ByteUpN) begin
          seg[SegReset] = 1'b1;
        end else if (dig != 3'd0 && text_byte_i >= ByteLowA) begin
          seg[SegFg] = 1'b1;
        end else if (dig != 3'd0) begin
          seg[SegBold] = 1'b1;
          seg[SegFg]   = 1'b1;
        end else begin
          // unknown code letter is taken as a fresh byte
          do_plain = 1'b1;
        end
      end
    end else if (slash_q) begin
      seg[SegPre] = (text_byte_i != ByteCaret);
      do_plain    = 1'b1;
    end else begin
      do_plain = 1'b1;
    end

    if (do_plain) begin
      if (text_byte_i == ByteNl) begin
        seg[SegReset] = colour_i;
        seg[SegCrlf]  = 1'b1;
      end else if (text_byte_i == ByteSlash) begin
        slash_d = 1'b1;
      end else if (text_byte_i == ByteCaret) begin
        caret_d = 1'b1;
      end else begin
        seg[SegByte] = 1'b1;
      end
    end

    // end of message flushes a held slash and drops a pending caret
    if (end_of_message_i) begin
      seg[SegPost] = slash_d;
      slash_d      = 1'b0;
      caret_d      = 1'b0;
    end
  end

  assign push_o       = accept && (seg != '0);
  assign cmd_o.seg    = seg;
  assign cmd_o.data   = text_byte_i;
  assign cmd_o.digit  = dig;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caret_q <= 1'b0;
      slash_q <= 1'b0;
    end else if (accept) begin
      caret_q <= caret_d;
      slash_q <= slash_d;
    end
  end

endmodule

// File: rtl/core/cmta_fifo.sv
// small command queue between front and back
module cmta_fifo #(
  parameter int unsigned Depth = cmta_pkg::FifoDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cmta_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output cmta_pkg::cmd_t head_o,
  output logic           empty_o
);
  import cmta_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/core/cmta_back.sv
// back end: walks each command's byte positions into the output register
module cmta_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  cmta_pkg::cmd_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     term_byte_o,
  output logic           last_of_run_o
);
  import cmta_pkg::*;

  pos_t       act_q, act_d;
  logic [7:0] data_q;
  logic [2:0] digit_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] term_q;
  logic       last_q;

  logic       use_head;
  logic       slot_free;
  pos_t       eff, pick, rest;
  logic [7:0] src_data;
  logic [2:0] src_digit;
  logic [PosW-1:0] idx;

  assign slot_free = !out_valid_q || out_ready_i;
  assign use_head  = (act_q == '0) && !empty_i;
  assign eff       = (act_q != '0) ? act_q : (empty_i ? '0 : expand_segs(head_i.seg));
  assign src_data  = use_head ? head_i.data : data_q;
  assign src_digit = use_head ? head_i.digit : digit_q;
  assign pick      = eff & (~eff + 1'b1);
  assign rest      = eff & ~pick;
  assign pop_o     = slot_free && use_head;

  always_comb begin
    idx = '0;
    for (int i = 0; i < NumPos; i++) begin
      if (pick[i]) begin
        idx = PosW'(i);
      end
    end
  end

  always_comb begin
    act_d       = act_q;
    out_valid_d = out_valid_q;
    if (slot_free) begin
      out_valid_d = (eff != '0);
      act_d       = rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q  <= head_i.data;
      digit_q <= head_i.digit;
    end
    if (slot_free && eff != '0) begin
      term_q <= pos_byte(idx, src_data, src_digit);
      last_q <= (rest == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      act_q       <= act_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign term_byte_o   = term_q;
  assign last_of_run_o = last_q;

endmodule

// File: rtl/core/caret_markup_to_ansi.sv
// top level: caret markup to ansi translator with apb configuration
// an accepted item is queued first, then its first byte is registered for output
// throughput: one output byte per cycle while out_ready_i is high; an item of n bytes
//   holds the back end until all n are out, and the front takes one item per cycle
//   while the command queue (Depth entries) has room; byteless items push no command
// reset: pending caret and slash cleared, queue and output emptied, colour enable set
module caret_markup_to_ansi #(
  parameter int unsigned Depth = cmta_pkg::FifoDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cmta_pkg::AddrW-1:0] paddr,
  input  logic [cmta_pkg::DataW-1:0] pwdata,
  output logic [cmta_pkg::DataW-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 text_byte_i,
  input  logic                       end_of_message_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 term_byte_o,
  output logic                       last_of_run_o
);
  import cmta_pkg::*;

  logic colour_q;
  logic push, full, pop, empty;
  cmd_t push_cmd, head_cmd;

  assign pready = 1'b1;
  assign prdata = (paddr == RegColourEnable) ? {{(DataW-1){1'b0}}, colour_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr == RegColourEnable) begin
      colour_q <= pwdata[0];
    end
  end

  cmta_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .colour_i         (colour_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .text_byte_i      (text_byte_i),
    .end_of_message_i (end_of_message_i),
    .full_i           (full),
    .push_o           (push),
    .cmd_o            (push_cmd)
  );

  cmta_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .empty_o     (empty)
  );

  cmta_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .term_byte_o   (term_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// File: tb/tb.sv
// testbench for the caret markup to ansi translator: directed and random text against a predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cmta_pkg::*;

  localparam int unsigned LimitCycles = 400000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned PhaseItems  = 36;
  localparam int unsigned LongHold    = 150;
  localparam int unsigned MaxReports  = 10;

  // foreground letters in digit order, digit 1 leftmost
  localparam logic [8*7-1:0]  FgLetters   = "rgybmcw";
  localparam logic [8*16-1:0] CodeLetters = "rgybmcwRGYBMCWHN";

  typedef struct packed {
    logic [7:0] term;
    logic       last;
  } term_t;

  class ansi_sb;
    logic       colour_en;
    logic       caret_pend;
    logic       slash_pend;
    logic [7:0] run_bytes[$];
    term_t      exp_term[$];
    int         items_in;
    int         bytes_checked;
    int         errors;

    function new();
      colour_en     = 1'b1;
      caret_pend    = 1'b0;
      slash_pend    = 1'b0;
      items_in      = 0;
      bytes_checked = 0;
      errors        = 0;
    endfunction

    function int pending();
      return exp_term.size();
    endfunction

    function logic [2:0] fg_digit(logic [7:0] b);
      logic [2:0] d;
      d = 3'd0;
      for (int i = 0; i < 7; i++) begin
        if ((b | 8'h20) == FgLetters[8*(6-i) +: 8]) d = 3'(i + 1);
      end
      return d;
    endfunction

    // ESC [ <c> m
    function void put_sgr(logic [7:0] c);
      run_bytes.push_back(ByteEsc);
      run_bytes.push_back(ByteLbr);
      run_bytes.push_back(c);
      run_bytes.push_back(ByteM);
    endfunction

    function void put_fg(logic [2:0] d);
      run_bytes.push_back(ByteEsc);
      run_bytes.push_back(ByteLbr);
      run_bytes.push_back(ByteThree);
      run_bytes.push_back(ByteZero + {5'd0, d});
      run_bytes.push_back(ByteM);
    endfunction

    function void put_plain(logic [7:0] b);
      if (b == ByteNl) begin
        if (colour_en) put_sgr(ByteZero);
        run_bytes.push_back(ByteCr);
        run_bytes.push_back(ByteNl);
      end else if (b == ByteSlash) begin
        slash_pend = 1'b1;
      end else if (b == ByteCaret) begin
        caret_pend = 1'b1;
      end else begin
        run_bytes.push_back(b);
      end
    endfunction

    function void put_code(logic [7:0] b);
      logic [2:0] d;
      d = fg_digit(b);
      if (!colour_en) return;
      if (b == ByteUpH) begin
        put_sgr(ByteOne);
      end else if (b == ByteUpN) begin
        put_sgr(ByteZero);
      end else if (d != 3'd0 && b >= ByteLowA) begin
        put_fg(d);
      end else if (d != 3'd0) begin
        put_sgr(ByteOne);
        put_fg(d);
      end else begin
        // unknown letter: caret dropped, letter taken as a fresh byte
        put_plain(b);
      end
    endfunction

    function void note_text_byte(logic [7:0] b, logic eom);
      term_t t;
      run_bytes.delete();
      if (caret_pend) begin
        caret_pend = 1'b0;
        put_code(b);
      end else if (slash_pend) begin
        slash_pend = 1'b0;
        if (b != ByteCaret) run_bytes.push_back(ByteSlash);
        put_plain(b);
      end else begin
        put_plain(b);
      end
      if (eom) begin
        if (slash_pend) run_bytes.push_back(ByteSlash);
        slash_pend = 1'b0;
        caret_pend = 1'b0;
      end
      foreach (run_bytes[k]) begin
        t.term = run_bytes[k];
        t.last = (k == run_bytes.size() - 1);
        exp_term.push_back(t);
      end
      items_in++;
    endfunction

    function void check_term_byte(logic [7:0] term, logic last);
      term_t e;
      bytes_checked++;
      if (exp_term.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("unexpected term byte %02h last %0b", term, last);
        return;
      end
      e = exp_term.pop_front();
      if (e.term !== term || e.last !== last) begin
        errors++;
        if (errors <= MaxReports)
          $display("term byte %0d: expected %02h last %0b, got %02h last %0b",
                   bytes_checked, e.term, e.last, term, last);
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrW-1:0]     paddr;
  logic [DataW-1:0]     pwdata;
  logic [DataW-1:0]     prdata;
  logic                 pready;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [7:0]           text_byte_i;
  logic                 end_of_message_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [7:0]           term_byte_o;
  logic                 last_of_run_o;

  ansi_sb sb;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     hold_left;
  int     cycles;
  int     settings;

  caret_markup_to_ansi i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .text_byte_i      (text_byte_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .term_byte_o      (term_byte_o),
    .last_of_run_o    (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("timeout after %0d cycles, %0d term bytes outstanding", cycles, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // input and output monitors
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_text_byte(text_byte_i, end_of_message_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_term_byte(term_byte_o, last_of_run_o);
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send(input logic [7:0] b, input logic eom);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    text_byte_i      <= b;
    end_of_message_i <= eom;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // wait a margin of DrainCycles after the last expected byte
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_colour(input logic v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegColourEnable;
    pwdata  <= {{(DataW-1){1'b0}}, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.colour_en = v;
    settings++;
  endtask

  initial begin
    int         n;
    int         k;
    logic [7:0] letter;
    bit         held;

    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    cycles         = 0;
    settings       = 0;
    held           = 1'b0;

    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_valid_i       <= 1'b0;
    text_byte_i      <= '0;
    end_of_message_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, colour on
    write_colour(1'b1);
    send("A", 1'b0);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send(ByteNl, 1'b0);
    send(ByteCaret, 1'b0); send("r", 1'b0);
    send(ByteCaret, 1'b0); send("W", 1'b0);
    send(ByteCaret, 1'b0); send(ByteUpH, 1'b0);
    send(ByteCaret, 1'b0); send(ByteUpN, 1'b0);
    send(ByteCaret, 1'b0); send("x", 1'b0);
    send(ByteCaret, 1'b0); send(ByteNl, 1'b0);
    send(ByteSlash, 1'b0); send(ByteCaret, 1'b0); send("g", 1'b0);
    send(ByteSlash, 1'b0); send("a", 1'b0);
    send(ByteSlash, 1'b1);
    send(ByteCaret, 1'b1);
    send(ByteCaret, 1'b0); send(ByteCaret, 1'b0); send("b", 1'b0);
    // caret left pending across a colour change
    send(ByteCaret, 1'b0);
    drain();
    write_colour(1'b0);
    send("R", 1'b0);
    send(ByteCaret, 1'b0); send(ByteNl, 1'b0);
    send(ByteNl, 1'b0);
    send(ByteSlash, 1'b0); send(ByteCaret, 1'b0); send("y", 1'b0);
    send(ByteCaret, 1'b0);
    drain();
    write_colour(1'b1);
    send("g", 1'b1);
    drain();

    // random phases: idle mix and colour setting change per phase
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      write_colour(p[0] ? 1'b0 : 1'b1);
      n = 0;
      while (n < PhaseItems) begin
        if (p == 0 && !held && n >= 6) begin
          hold_left = LongHold;
          held      = 1'b1;
        end
        k      = $urandom_range(99);
        letter = ($urandom_range(99) < 85) ? CodeLetters[8*$urandom_range(15) +: 8]
                                           : 8'($urandom_range(255));
        if (k < 30) begin
          send(ByteCaret, $urandom_range(19) == 0);
          send(letter, $urandom_range(9) == 0);
          n += 2;
        end else if (k < 40) begin
          send(ByteSlash, 1'b0);
          send(ByteCaret, 1'b0);
          send(letter, $urandom_range(9) == 0);
          n += 3;
        end else if (k < 50) begin
          send(ByteNl, $urandom_range(9) == 0);
          n++;
        end else if (k < 62) begin
          send(8'($urandom_range(255)), $urandom_range(9) == 0);
          n++;
        end else begin
          send(8'($urandom_range(8'h20, 8'h7E)), $urandom_range(9) == 0);
          n++;
        end
      end
      drain();
    end

    $display("%0d text items in, %0d terminal bytes checked, %0d colour settings written",
             sb.items_in, sb.bytes_checked, settings);
    $display("idle mixes: none, sender 57%%, receiver 57%%, both 25%%; one %0d-cycle hold-off",
             LongHold);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d term bytes never seen", sb.errors, sb.pending());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
